### sv/vasu_pkg.sv
// Shared types, constants and helpers for the voice allocator with priority stealing.
package vasu_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int PRIORITY_BITS = 3;

  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int PRI_W    = PRIORITY_BITS;
  localparam int PRI_IN_W = 3;
  localparam int HANDLE_W = 32;
  localparam int CLASS_W  = 2;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_2D_RST     = LIMIT_W'(32);
  localparam logic [LIMIT_W-1:0] LIMIT_3D_RST     = LIMIT_W'(32);
  localparam logic [LIMIT_W-1:0] LIMIT_STREAM_RST = LIMIT_W'(8);

  localparam logic [CLASS_W-1:0] CLASS_2D     = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_3D     = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_STREAM = 2'd2;

  typedef enum logic [1:0] {
    REQ_PLAY   = 2'd0,
    REQ_STOP   = 2'd1,
    REQ_PAUSE  = 2'd2,
    REQ_RETIRE = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_VICTIM = 3'd1,
    ST_CLOSED    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_ADMISSION    = 2'd0,
    CFG_LIMIT_2D     = 2'd1,
    CFG_LIMIT_3D     = 2'd2,
    CFG_LIMIT_STREAM = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EVAL,
    S_SHIFT,
    S_APPEND,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [CLASS_W-1:0]  cls;
    logic [PRI_W-1:0]    pri;
    logic                stopping;
    logic                paused;
  } entry_t;

  typedef struct packed {
    logic               admission_open;
    logic [LIMIT_W-1:0] limit_2d;
    logic [LIMIT_W-1:0] limit_3d;
    logic [LIMIT_W-1:0] limit_stream;
  } cfg_t;

  typedef struct packed {
    logic                clear;
    logic                valid;
    logic [IDX_W-1:0]    idx;
    logic [HANDLE_W-1:0] key;
    logic [CLASS_W-1:0]  cls;
    logic [PRI_W-1:0]    pri;
  } scan_ctl_t;

  typedef struct packed {
    logic                match_found;
    logic [IDX_W-1:0]    match_idx;
    entry_t              match_entry;
    logic [CNT_W-1:0]    cls_cnt;
    logic                best_found;
    logic [IDX_W-1:0]    best_idx;
    logic [PRI_W-1:0]    best_pri;
    logic [HANDLE_W-1:0] best_handle;
  } scan_res_t;

  function automatic logic [PRI_W-1:0] mask_priority(input logic [PRI_IN_W-1:0] p);
    logic [PRI_IN_W+PRI_W-1:0] w;
    w = {{PRI_W{1'b0}}, p};
    return w[PRI_W-1:0];
  endfunction

endpackage

### sv/voice_allocator_priority_steal_unit.sv
// Top level of the voice allocator: configuration registers, table memory, scan unit and sequencer.
// One word at a time: a new word is taken only once the last result is loaded into the output
// register. Stop, pause, retire and play each scan the live entries through the single table
// read port; a play refused for closed admission skips the scan.
// Results wait in an output register. Reset clears the entry count, closes admission and
// loads the default class limits; the table memory is not cleared, as only live slots are read.
module voice_allocator_priority_steal_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [vasu_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      req_type_i,
  input  logic [vasu_pkg::HANDLE_W-1:0]   handle_i,
  input  logic [vasu_pkg::CLASS_W-1:0]    voice_class_i,
  input  logic [vasu_pkg::PRI_IN_W-1:0]   priority_req_i,
  input  logic                            forced_i,
  input  logic                            kill_valid_i,
  input  logic [vasu_pkg::HANDLE_W-1:0]   kill_handle_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vasu_pkg::STATUS_W-1:0]   status_o,
  output logic                            victim_valid_o,
  output logic [vasu_pkg::HANDLE_W-1:0]   victim_handle_o
);

  vasu_pkg::cfg_t       cfg_q, cfg_d;
  logic                 ram_we;
  logic [vasu_pkg::IDX_W-1:0] ram_waddr;
  vasu_pkg::entry_t     ram_wdata;
  logic                 ram_re;
  logic [vasu_pkg::IDX_W-1:0] ram_raddr;
  vasu_pkg::entry_t     ram_rdata;
  vasu_pkg::scan_ctl_t  scan_ctl;
  vasu_pkg::scan_res_t  scan_res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (vasu_pkg::cfg_reg_e'(cfg_index_i))
        vasu_pkg::CFG_ADMISSION:    cfg_d.admission_open = cfg_wdata_i[0];
        vasu_pkg::CFG_LIMIT_2D:     cfg_d.limit_2d       = cfg_wdata_i;
        vasu_pkg::CFG_LIMIT_3D:     cfg_d.limit_3d       = cfg_wdata_i;
        vasu_pkg::CFG_LIMIT_STREAM: cfg_d.limit_stream   = cfg_wdata_i;
        default:                    cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.admission_open <= 1'b0;
      cfg_q.limit_2d       <= vasu_pkg::LIMIT_2D_RST;
      cfg_q.limit_3d       <= vasu_pkg::LIMIT_3D_RST;
      cfg_q.limit_stream   <= vasu_pkg::LIMIT_STREAM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vasu_ram #(
    .DEPTH (vasu_pkg::TABLE_DEPTH),
    .WIDTH ($bits(vasu_pkg::entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vasu_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .entry_i (ram_rdata),
    .res_o   (scan_res)
  );

  vasu_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .handle_i        (handle_i),
    .voice_class_i   (voice_class_i),
    .priority_req_i  (priority_req_i),
    .forced_i        (forced_i),
    .kill_valid_i    (kill_valid_i),
    .kill_handle_i   (kill_handle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .victim_valid_o  (victim_valid_o),
    .victim_handle_o (victim_handle_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .scan_ctl_o      (scan_ctl),
    .scan_res_i      (scan_res)
  );

endmodule

### sv/vasu_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
module vasu_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 39
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/vasu_scan.sv
// Shared scan unit: handle match, class count and lowest-priority victim search.
module vasu_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vasu_pkg::scan_ctl_t   ctl_i,
  input  vasu_pkg::entry_t      entry_i,
  output vasu_pkg::scan_res_t   res_o
);

  logic                           match_found_q, match_found_d;
  logic [vasu_pkg::IDX_W-1:0]     match_idx_q, match_idx_d;
  vasu_pkg::entry_t               match_entry_q, match_entry_d;
  logic [vasu_pkg::CNT_W-1:0]     cls_cnt_q, cls_cnt_d;
  logic                           best_found_q, best_found_d;
  logic [vasu_pkg::IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [vasu_pkg::PRI_W-1:0]     best_pri_q, best_pri_d;
  logic [vasu_pkg::HANDLE_W-1:0]  best_handle_q, best_handle_d;
  logic                           cls_hit;

  always_comb begin
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    match_entry_d = match_entry_q;
    cls_cnt_d     = cls_cnt_q;
    best_found_d  = best_found_q;
    best_idx_d    = best_idx_q;
    best_pri_d    = best_pri_q;
    best_handle_d = best_handle_q;
    cls_hit       = (entry_i.cls == ctl_i.cls);
    if (ctl_i.clear) begin
      match_found_d = 1'b0;
      cls_cnt_d     = '0;
      best_found_d  = 1'b0;
    end else if (ctl_i.valid) begin
      if (!match_found_q && (entry_i.handle == ctl_i.key)) begin
        match_found_d = 1'b1;
        match_idx_d   = ctl_i.idx;
        match_entry_d = entry_i;
      end
      if (cls_hit) begin
        cls_cnt_d = cls_cnt_q + vasu_pkg::CNT_W'(1);
      end
      if (cls_hit && (entry_i.pri < ctl_i.pri) &&
          (!best_found_q || (entry_i.pri < best_pri_q))) begin
        best_found_d  = 1'b1;
        best_idx_d    = ctl_i.idx;
        best_pri_d    = entry_i.pri;
        best_handle_d = entry_i.handle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      cls_cnt_q     <= '0;
      best_found_q  <= 1'b0;
    end else begin
      match_found_q <= match_found_d;
      cls_cnt_q     <= cls_cnt_d;
      best_found_q  <= best_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q   <= match_idx_d;
    match_entry_q <= match_entry_d;
    best_idx_q    <= best_idx_d;
    best_pri_q    <= best_pri_d;
    best_handle_q <= best_handle_d;
  end

  always_comb begin
    res_o.match_found = match_found_q;
    res_o.match_idx   = match_idx_q;
    res_o.match_entry = match_entry_q;
    res_o.cls_cnt     = cls_cnt_q;
    res_o.best_found  = best_found_q;
    res_o.best_idx    = best_idx_q;
    res_o.best_pri    = best_pri_q;
    res_o.best_handle = best_handle_q;
  end

endmodule

### sv/vasu_seq.sv
// Request sequencer: scans, marks, compacts and appends table entries, and holds the result.
module vasu_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vasu_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      req_type_i,
  input  logic [vasu_pkg::HANDLE_W-1:0]   handle_i,
  input  logic [vasu_pkg::CLASS_W-1:0]    voice_class_i,
  input  logic [vasu_pkg::PRI_IN_W-1:0]   priority_req_i,
  input  logic                            forced_i,
  input  logic                            kill_valid_i,
  input  logic [vasu_pkg::HANDLE_W-1:0]   kill_handle_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vasu_pkg::STATUS_W-1:0]   status_o,
  output logic                            victim_valid_o,
  output logic [vasu_pkg::HANDLE_W-1:0]   victim_handle_o,
  output logic                            ram_we_o,
  output logic [vasu_pkg::IDX_W-1:0]      ram_waddr_o,
  output vasu_pkg::entry_t                ram_wdata_o,
  output logic                            ram_re_o,
  output logic [vasu_pkg::IDX_W-1:0]      ram_raddr_o,
  input  vasu_pkg::entry_t                ram_rdata_i,
  output vasu_pkg::scan_ctl_t             scan_ctl_o,
  input  vasu_pkg::scan_res_t             scan_res_i
);

  vasu_pkg::state_e               state_q, state_d;
  vasu_pkg::req_e                 req_q, req_d;
  logic [vasu_pkg::HANDLE_W-1:0]  handle_q, handle_d;
  logic [vasu_pkg::HANDLE_W-1:0]  key_q, key_d;
  logic [vasu_pkg::CLASS_W-1:0]   cls_q, cls_d;
  logic [vasu_pkg::PRI_W-1:0]     pri_q, pri_d;
  logic                           forced_q, forced_d;
  logic                           kill_q, kill_d;
  logic [vasu_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [vasu_pkg::CNT_W-1:0]     count_q, count_d;
  logic                           rd_vld_q;
  logic [vasu_pkg::IDX_W-1:0]     rd_idx_q;
  vasu_pkg::status_e              st_q, st_d;
  logic                           vv_q, vv_d;
  logic [vasu_pkg::HANDLE_W-1:0]  vh_q, vh_d;
  logic                           out_valid_q, out_valid_d;
  vasu_pkg::status_e              out_status_q;
  logic                           out_vv_q;
  logic [vasu_pkg::HANDLE_W-1:0]  out_vh_q;
  logic                           out_load;
  logic [vasu_pkg::LIMIT_W-1:0]   limit;
  logic                           over_limit;
  vasu_pkg::entry_t               new_entry;

  always_comb begin
    unique case (cls_q)
      vasu_pkg::CLASS_2D:     limit = cfg_i.limit_2d;
      vasu_pkg::CLASS_3D:     limit = cfg_i.limit_3d;
      vasu_pkg::CLASS_STREAM: limit = cfg_i.limit_stream;
      default:                limit = '0;
    endcase
  end

  assign over_limit = !forced_q &&
      (vasu_pkg::CMP_W'(scan_res_i.cls_cnt) >= vasu_pkg::CMP_W'(limit));

  always_comb begin
    new_entry.handle   = handle_q;
    new_entry.cls      = cls_q;
    new_entry.pri      = pri_q;
    new_entry.stopping = 1'b0;
    new_entry.paused   = 1'b0;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    handle_d    = handle_q;
    key_d       = key_q;
    cls_d       = cls_q;
    pri_d       = pri_q;
    forced_d    = forced_q;
    kill_d      = kill_q;
    idx_d       = idx_q;
    count_d     = count_q;
    st_d        = st_q;
    vv_d        = vv_q;
    vh_d        = vh_q;
    out_load    = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q[vasu_pkg::IDX_W-1:0];
    ram_we_o    = 1'b0;
    ram_waddr_o = rd_idx_q - vasu_pkg::IDX_W'(1);
    ram_wdata_o = ram_rdata_i;
    in_ready_o  = 1'b0;

    // Compaction: each word read one slot up is written one slot down.
    if ((state_q == vasu_pkg::S_SHIFT) && rd_vld_q) begin
      ram_we_o = 1'b1;
    end

    unique case (state_q)
      vasu_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d    = vasu_pkg::req_e'(req_type_i);
          handle_d = handle_i;
          cls_d    = voice_class_i;
          pri_d    = vasu_pkg::mask_priority(priority_req_i);
          forced_d = forced_i;
          kill_d   = kill_valid_i;
          key_d    = (vasu_pkg::req_e'(req_type_i) == vasu_pkg::REQ_PLAY) ?
                     kill_handle_i : handle_i;
          idx_d    = '0;
          st_d     = vasu_pkg::ST_OK;
          vv_d     = 1'b0;
          vh_d     = '0;
          if ((vasu_pkg::req_e'(req_type_i) == vasu_pkg::REQ_PLAY) &&
              !cfg_i.admission_open) begin
            st_d    = vasu_pkg::ST_CLOSED;
            state_d = vasu_pkg::S_DONE;
          end else begin
            state_d = vasu_pkg::S_SCAN;
          end
        end
      end
      vasu_pkg::S_SCAN: begin
        if (idx_q < count_q) begin
          ram_re_o = 1'b1;
          idx_d    = idx_q + vasu_pkg::CNT_W'(1);
        end else begin
          state_d = vasu_pkg::S_DECIDE;
        end
      end
      vasu_pkg::S_DECIDE: begin
        ram_waddr_o = scan_res_i.match_idx;
        ram_wdata_o = scan_res_i.match_entry;
        if (req_q == vasu_pkg::REQ_PLAY) begin
          if (kill_q && scan_res_i.match_found) begin
            ram_we_o             = 1'b1;
            ram_wdata_o.stopping = 1'b1;
          end
          state_d = vasu_pkg::S_EVAL;
        end else if (!scan_res_i.match_found) begin
          st_d    = vasu_pkg::ST_NOT_FOUND;
          state_d = vasu_pkg::S_DONE;
        end else begin
          unique case (req_q)
            vasu_pkg::REQ_STOP: begin
              ram_we_o             = 1'b1;
              ram_wdata_o.stopping = 1'b1;
              state_d              = vasu_pkg::S_DONE;
            end
            vasu_pkg::REQ_PAUSE: begin
              ram_we_o           = 1'b1;
              ram_wdata_o.paused = 1'b1;
              state_d            = vasu_pkg::S_DONE;
            end
            default: begin
              idx_d   = vasu_pkg::CNT_W'(scan_res_i.match_idx) + vasu_pkg::CNT_W'(1);
              state_d = vasu_pkg::S_SHIFT;
            end
          endcase
        end
      end
      vasu_pkg::S_EVAL: begin
        if (!over_limit) begin
          state_d = vasu_pkg::S_APPEND;
        end else if (scan_res_i.best_found) begin
          vv_d    = 1'b1;
          vh_d    = scan_res_i.best_handle;
          idx_d   = vasu_pkg::CNT_W'(scan_res_i.best_idx) + vasu_pkg::CNT_W'(1);
          state_d = vasu_pkg::S_SHIFT;
        end else begin
          st_d    = vasu_pkg::ST_NO_VICTIM;
          state_d = vasu_pkg::S_DONE;
        end
      end
      vasu_pkg::S_SHIFT: begin
        if (idx_q < count_q) begin
          ram_re_o = 1'b1;
          idx_d    = idx_q + vasu_pkg::CNT_W'(1);
        end else begin
          count_d = count_q - vasu_pkg::CNT_W'(1);
          state_d = (req_q == vasu_pkg::REQ_PLAY) ? vasu_pkg::S_APPEND : vasu_pkg::S_DONE;
        end
      end
      vasu_pkg::S_APPEND: begin
        if (count_q == vasu_pkg::CNT_W'(vasu_pkg::TABLE_DEPTH)) begin
          st_d = vasu_pkg::ST_FULL;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = count_q[vasu_pkg::IDX_W-1:0];
          ram_wdata_o = new_entry;
          count_d     = count_q + vasu_pkg::CNT_W'(1);
        end
        state_d = vasu_pkg::S_DONE;
      end
      vasu_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = vasu_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = vasu_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vasu_pkg::S_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= ram_re_o;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    handle_q <= handle_d;
    key_q    <= key_d;
    cls_q    <= cls_d;
    pri_q    <= pri_d;
    forced_q <= forced_d;
    kill_q   <= kill_d;
    idx_q    <= idx_d;
    st_q     <= st_d;
    vv_q     <= vv_d;
    vh_q     <= vh_d;
    rd_idx_q <= ram_raddr_o;
    if (out_load) begin
      out_status_q <= st_q;
      out_vv_q     <= vv_q;
      out_vh_q     <= vh_q;
    end
  end

  always_comb begin
    scan_ctl_o.clear = (state_q == vasu_pkg::S_IDLE) && in_valid_i;
    scan_ctl_o.valid = (state_q == vasu_pkg::S_SCAN) && rd_vld_q;
    scan_ctl_o.idx   = rd_idx_q;
    scan_ctl_o.key   = key_q;
    scan_ctl_o.cls   = cls_q;
    scan_ctl_o.pri   = pri_q;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign victim_valid_o  = out_vv_q;
  assign victim_handle_o = out_vh_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vasu_pkg::CNT_W'(vasu_pkg::TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) ||
    (count_q == $past(count_q) + vasu_pkg::CNT_W'(1)) ||
    (count_q == $past(count_q) - vasu_pkg::CNT_W'(1)))
    else $error("Entry count moved by more than one in a cycle.");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vasu_pkg::S_SCAN) |-> !ram_we_o)
    else $error("Table written during a scan.");

  a_victim_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_vv_q) |-> (out_status_q == vasu_pkg::ST_OK))
    else $error("Victim reported with a failing status.");

endmodule

### bench/voice_table_model_pkg.sv
// Request and reply word types and the scoreboard class that predicts the voice table's replies.
package voice_table_model_pkg;
  import vasu_pkg::*;

  localparam logic [CLASS_W-1:0] CLASS_SPARE = 2'd3;

  typedef struct {
    req_e                kind;
    logic [HANDLE_W-1:0] handle;
    logic [CLASS_W-1:0]  cls;
    logic [PRI_IN_W-1:0] pri;
    logic                forced;
    logic                kill_valid;
    logic [HANDLE_W-1:0] kill_handle;
  } alloc_req_t;

  typedef struct {
    status_e             status;
    logic                victim_valid;
    logic [HANDLE_W-1:0] victim_handle;
  } alloc_resp_t;

  class voice_table_model;
    logic [HANDLE_W-1:0] slot_handle [TABLE_DEPTH];
    logic [CLASS_W-1:0]  slot_class [TABLE_DEPTH];
    logic [PRI_W-1:0]    slot_pri [TABLE_DEPTH];
    logic                slot_stopping [TABLE_DEPTH];
    logic                slot_paused [TABLE_DEPTH];
    int                  live;
    logic                admission_open;
    int                  limit_2d;
    int                  limit_3d;
    int                  limit_stream;
    alloc_resp_t         expected_replies [$];
    int                  mismatches;

    function new();
      live = 0;
      admission_open = 1'b0;
      limit_2d = LIMIT_2D_RST;
      limit_3d = LIMIT_3D_RST;
      limit_stream = LIMIT_STREAM_RST;
      mismatches = 0;
    endfunction

    function void set_config(logic adm, int l2, int l3, int ls);
      admission_open = adm;
      limit_2d = l2;
      limit_3d = l3;
      limit_stream = ls;
    endfunction

    function int find_handle(logic [HANDLE_W-1:0] h);
      for (int i = 0; i < live; i++) begin
        if (slot_handle[i] == h) return i;
      end
      return -1;
    endfunction

    function void remove_slot(int s);
      for (int i = s; i + 1 < live; i++) begin
        slot_handle[i] = slot_handle[i+1];
        slot_class[i] = slot_class[i+1];
        slot_pri[i] = slot_pri[i+1];
        slot_stopping[i] = slot_stopping[i+1];
        slot_paused[i] = slot_paused[i+1];
      end
      live--;
    endfunction

    function int class_limit(logic [CLASS_W-1:0] c);
      case (c)
        CLASS_2D: return limit_2d;
        CLASS_3D: return limit_3d;
        CLASS_STREAM: return limit_stream;
        default: return 0;
      endcase
    endfunction

    function int class_count(logic [CLASS_W-1:0] c);
      int n;
      n = 0;
      for (int i = 0; i < live; i++) begin
        if (slot_class[i] == c) n++;
      end
      return n;
    endfunction

    function void note_request(alloc_req_t r);
      alloc_resp_t e;
      int          s;
      int          best;
      logic [PRI_W-1:0] pri;
      logic        admit;
      e.status = ST_OK;
      e.victim_valid = 1'b0;
      e.victim_handle = '0;
      pri = PRI_W'(r.pri) & PRI_W'((1 << PRIORITY_BITS) - 1);
      if (r.kind == REQ_PLAY) begin
        if (!admission_open) begin
          e.status = ST_CLOSED;
        end else begin
          admit = 1'b1;
          if (r.kill_valid) begin
            s = find_handle(r.kill_handle);
            if (s >= 0) slot_stopping[s] = 1'b1;
          end
          if (!r.forced && class_count(r.cls) >= class_limit(r.cls)) begin
            best = -1;
            for (int i = 0; i < live; i++) begin
              if (slot_class[i] == r.cls && slot_pri[i] < pri &&
                  (best < 0 || slot_pri[i] < slot_pri[best])) begin
                best = i;
              end
            end
            if (best < 0) begin
              e.status = ST_NO_VICTIM;
              admit = 1'b0;
            end else begin
              e.victim_valid = 1'b1;
              e.victim_handle = slot_handle[best];
              remove_slot(best);
            end
          end
          if (admit) begin
            if (live >= TABLE_DEPTH) begin
              e.status = ST_FULL;
            end else begin
              slot_handle[live] = r.handle;
              slot_class[live] = r.cls;
              slot_pri[live] = pri;
              slot_stopping[live] = 1'b0;
              slot_paused[live] = 1'b0;
              live++;
            end
          end
        end
      end else begin
        s = find_handle(r.handle);
        if (s < 0) begin
          e.status = ST_NOT_FOUND;
        end else begin
          case (r.kind)
            REQ_STOP: slot_stopping[s] = 1'b1;
            REQ_PAUSE: slot_paused[s] = 1'b1;
            default: remove_slot(s);
          endcase
        end
      end
      expected_replies.insert(expected_replies.size(), e);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic vv, logic [HANDLE_W-1:0] vh);
      alloc_resp_t e;
      if (expected_replies.size() == 0) begin
        $error("unexpected reply word: status %0d victim_valid %0d victim_handle %h",
               st, vv, vh);
        mismatches++;
        return;
      end
      e = expected_replies.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        mismatches++;
      end
      if (vv !== e.victim_valid) begin
        $error("victim_valid: expected %0d, actual %0d", e.victim_valid, vv);
        mismatches++;
      end
      if (vh !== e.victim_handle) begin
        $error("victim_handle: expected %h, actual %h", e.victim_handle, vh);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### bench/tb_top.sv
// Top level of the testbench: clock, reset, stimulus and reply handling around the voice allocator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vasu_pkg::*;
  import voice_table_model_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [HANDLE_W-1:0] HANDLE_BASE = 32'h0000_0100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_index_i = CFG_ADMISSION;
  logic [LIMIT_W-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          req_type_i = REQ_PLAY;
  logic [HANDLE_W-1:0] handle_i = '0;
  logic [CLASS_W-1:0]  voice_class_i = CLASS_2D;
  logic [PRI_IN_W-1:0] priority_req_i = '0;
  logic                forced_i = 1'b0;
  logic                kill_valid_i = 1'b0;
  logic [HANDLE_W-1:0] kill_handle_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                victim_valid_o;
  logic [HANDLE_W-1:0] victim_handle_o;

  voice_table_model table_model;
  int                cycle_count = 0;
  int                replies_seen = 0;
  int                send_run = 0;

  voice_allocator_priority_steal_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .handle_i        (handle_i),
    .voice_class_i   (voice_class_i),
    .priority_req_i  (priority_req_i),
    .forced_i        (forced_i),
    .kill_valid_i    (kill_valid_i),
    .kill_handle_i   (kill_handle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .victim_valid_o  (victim_valid_o),
    .victim_handle_o (victim_handle_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_gap(ref int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle(int live_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (table_model.live != 0 && roll < live_pct) begin
      return table_model.slot_handle[$urandom_range(0, table_model.live - 1)];
    end
    if (roll < 92) return HANDLE_BASE + HANDLE_W'($urandom_range(0, 23));
    return $urandom();
  endfunction

  function automatic alloc_req_t word_of(req_e kind, logic [HANDLE_W-1:0] h,
                                         logic [CLASS_W-1:0] cls, logic [PRI_IN_W-1:0] pri,
                                         logic forced, logic kv, logic [HANDLE_W-1:0] kh);
    alloc_req_t w;
    w.kind = kind;
    w.handle = h;
    w.cls = cls;
    w.pri = pri;
    w.forced = forced;
    w.kill_valid = kv;
    w.kill_handle = kh;
    return w;
  endfunction

  function automatic alloc_req_t random_word(int play_pct, int retire_pct, int forced_pct);
    alloc_req_t w;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < play_pct) w.kind = REQ_PLAY;
    else if (roll < play_pct + retire_pct) w.kind = REQ_RETIRE;
    else if (roll[0]) w.kind = REQ_STOP;
    else w.kind = REQ_PAUSE;
    w.handle = pick_handle((w.kind == REQ_PLAY) ? 10 : 75);
    w.cls = ($urandom_range(0, 11) == 0) ? CLASS_SPARE :
            CLASS_W'($urandom_range(CLASS_2D, CLASS_STREAM));
    w.pri = PRI_IN_W'($urandom_range(0, 7));
    w.forced = ($urandom_range(0, 99) < forced_pct);
    w.kill_valid = ($urandom_range(0, 3) == 0);
    w.kill_handle = pick_handle(70);
    return w;
  endfunction

  task automatic send_word(input alloc_req_t w);
    int gap;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= w.kind;
    handle_i <= w.handle;
    voice_class_i <= w.cls;
    priority_req_i <= w.pri;
    forced_i <= w.forced;
    kill_valid_i <= w.kill_valid;
    kill_handle_i <= w.kill_handle;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    table_model.note_request(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (table_model.expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(logic adm, int l2, int l3, int ls);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_ADMISSION;
    cfg_wdata_i <= LIMIT_W'(adm);
    @(posedge clk_i);
    cfg_index_i <= CFG_LIMIT_2D;
    cfg_wdata_i <= LIMIT_W'(l2);
    @(posedge clk_i);
    cfg_index_i <= CFG_LIMIT_3D;
    cfg_wdata_i <= LIMIT_W'(l3);
    @(posedge clk_i);
    cfg_index_i <= CFG_LIMIT_STREAM;
    cfg_wdata_i <= LIMIT_W'(ls);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_model.set_config(adm, l2, l3, ls);
  endtask

  task automatic run_phase(logic adm, int l2, int l3, int ls, int words,
                           int play_pct, int retire_pct, int forced_pct);
    drain();
    write_config(adm, l2, l3, ls);
    repeat (words) send_word(random_word(play_pct, retire_pct, forced_pct));
  endtask

  // The one long hold-off lets the block fill up and stall its input.
  task automatic run_receiver();
    int run_left;
    int stall;
    run_left = 0;
    forever begin
      stall = draw_gap(run_left);
      if (replies_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      table_model.check_result(status_o, victim_valid_o, victim_handle_o);
      replies_seen++;
    end
  endtask

  initial begin
    table_model = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      run_receiver();
    join_none

    send_word(word_of(REQ_PLAY, 32'h0000_0001, CLASS_2D, 3'd4, 1'b0, 1'b1, 32'h0000_0001));
    send_word(word_of(REQ_STOP, 32'h0000_0000, CLASS_3D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    drain();
    write_config(1'b1, 1, 64, 0);
    send_word(word_of(REQ_PLAY, 32'hFFFF_FFFF, CLASS_2D, 3'd7, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_word(word_of(REQ_PLAY, 32'h0000_0000, CLASS_2D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_0000, CLASS_3D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_0000, CLASS_3D, 3'd3, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_STOP, 32'h0000_0000, CLASS_2D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PAUSE, 32'h0000_0000, CLASS_2D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_RETIRE, 32'h0000_0000, CLASS_2D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_0005, CLASS_STREAM, 3'd7, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_0006, CLASS_STREAM, 3'd1, 1'b1, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_0007, CLASS_STREAM, 3'd0, 1'b1, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_0008, CLASS_STREAM, 3'd5, 1'b0, 1'b1, 32'h0000_0006));
    send_word(word_of(REQ_PLAY, 32'h0000_0009, CLASS_SPARE, 3'd7, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_000A, CLASS_SPARE, 3'd2, 1'b1, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_000B, CLASS_SPARE, 3'd2, 1'b1, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_000C, CLASS_SPARE, 3'd7, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'h0000_000D, CLASS_2D, 3'd7, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_RETIRE, 32'hFFFF_FFFF, CLASS_2D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_RETIRE, 32'hFFFF_FFFF, CLASS_2D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PAUSE, 32'h0001_2345, CLASS_2D, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
    send_word(word_of(REQ_PLAY, 32'hAAAA_AAAA, CLASS_2D, 3'd3, 1'b0, 1'b1, 32'h5555_5555));
    send_word(word_of(REQ_PLAY, 32'h5555_5555, CLASS_2D, 3'd6, 1'b0, 1'b1, 32'h0000_000B));

    run_phase(1'b1, 2, 3, 1, 150, 60, 15, 10);
    run_phase(1'b1, 0, 0, 0, 100, 65, 15, 30);
    run_phase(1'b1, 64, 64, 64, 220, 85, 5, 50);
    run_phase(1'b0, 64, 64, 64, 80, 30, 50, 0);
    run_phase(1'b1, 8, 4, 2, 300, 45, 30, 10);
    run_phase(1'b1, 63, 1, 0, 200, 50, 25, 20);
    run_phase(1'b1, 32, 32, 8, 100, 50, 25, 10);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (table_model.mismatches == 0 && table_model.expected_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
